[rtl/core/dise_pkg.sv]
// Shared types, codes and helpers for the disk image sector expander.
`timescale 1ns / 1ps
`default_nettype none

package dise_pkg;

    // Result classes
    localparam logic RES_RUN   = 1'b0;
    localparam logic RES_ERROR = 1'b1;

    // Error report codes
    localparam logic [2:0] ERR_MAGIC   = 3'd0;
    localparam logic [2:0] ERR_MODE    = 3'd1;
    localparam logic [2:0] ERR_CYL     = 3'd2;
    localparam logic [2:0] ERR_HEAD    = 3'd3;
    localparam logic [2:0] ERR_SIZE    = 3'd4;
    localparam logic [2:0] ERR_COUNT   = 3'd5;
    localparam logic [2:0] ERR_RECTYPE = 3'd6;

    // Record kinds as reported on the output
    localparam logic [1:0] KIND_NORMAL     = 2'd0;
    localparam logic [1:0] KIND_DELETED    = 2'd1;
    localparam logic [1:0] KIND_COMPRESSED = 2'd2;
    localparam logic [1:0] KIND_UNAVAIL    = 2'd3;

    // Sector record type bytes in the file
    localparam logic [7:0] REC_UNAVAIL          = 8'd0;
    localparam logic [7:0] REC_NORMAL           = 8'd1;
    localparam logic [7:0] REC_COMPRESSED       = 8'd2;
    localparam logic [7:0] REC_DELETED          = 8'd3;
    localparam logic [7:0] REC_DELETED_COMP     = 8'd4;
    localparam logic [7:0] REC_NORMAL_ERR       = 8'd5;
    localparam logic [7:0] REC_COMPRESSED_ERR   = 8'd6;
    localparam logic [7:0] REC_DELETED_ERR      = 8'd7;
    localparam logic [7:0] REC_DELETED_COMP_ERR = 8'd8;

    // Configuration register indexes
    localparam logic CFG_MAX_CYLINDER = 1'b0;
    localparam logic CFG_FILL_BYTE    = 1'b1;

    localparam logic [7:0] MAX_CYLINDER_RESET = 8'd80;
    localparam logic [7:0] FILL_BYTE_RESET    = 8'hE5;

    localparam logic [7:0] COMMENT_END = 8'h1A;
    localparam logic [7:0] MAX_MODE    = 8'd5;
    localparam logic [7:0] MAX_HEAD    = 8'd1;
    localparam logic [7:0] MAX_SIZE_CODE = 8'd6;

    localparam logic [7:0] MAGIC_0 = 8'h49;  // 'I'
    localparam logic [7:0] MAGIC_1 = 8'h4D;  // 'M'
    localparam logic [7:0] MAGIC_2 = 8'h44;  // 'D'

    typedef struct packed {
        logic       kind;
        logic [2:0] error_code;
        logic [7:0] run_value;
        logic [13:0] run_length;
        logic [7:0] cylinder;
        logic       head;
        logic [7:0] sector_number;
        logic [1:0] record_kind;
        logic       sector_end;
    } result_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = MAGIC_0;
            2'd1:    b = MAGIC_1;
            default: b = MAGIC_2;
        endcase
        return b;
    endfunction

    // 128 << code, for codes up to 6
    function automatic logic [13:0] sector_size(input logic [2:0] code);
        return 14'd128 << code;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dise_front.sv]
// Front end: byte parser, track state, numbering map and result classification.
`timescale 1ns / 1ps
`default_nettype none

module dise_front #(
    parameter int MAX_SECTORS      = 32,
    parameter int MAX_SECTOR_BYTES = 8192
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        in_byte,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [7:0]        cfg_data,
    output logic                   res_valid,
    output dise_pkg::result_t      res
);

    localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_COMMENT, PH_MODE, PH_CYL, PH_HEAD, PH_COUNT,
        PH_SIZE, PH_MAP, PH_TYPE, PH_DATA, PH_FILL, PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  magic_index_reg, magic_index_next;
    logic [7:0]  cyl_reg, cyl_next;
    logic        head_reg, head_next;
    logic [7:0]  total_reg, total_next;
    logic [2:0]  size_code_reg, size_code_next;
    logic [7:0]  idx_reg, idx_next;
    logic [13:0] count_reg, count_next;
    logic [1:0]  kind_reg, kind_next;
    logic        error_reg, error_next;
    logic [7:0]  max_cyl_reg;
    logic [7:0]  fill_reg;

    logic [7:0]  map_mem [MAX_SECTORS];
    logic [7:0]  map_rd_reg;
    logic        map_we;

    logic [13:0] cur_size;
    logic [13:0] new_size;
    logic [7:0]  idx_inc;

    assign cur_size = dise_pkg::sector_size(size_code_reg);
    assign new_size = dise_pkg::sector_size(in_byte[2:0]);
    assign idx_inc  = 8'(idx_reg + 8'd1);

    always_comb
    begin
        phase_next       = phase_reg;
        magic_index_next = magic_index_reg;
        cyl_next         = cyl_reg;
        head_next        = head_reg;
        total_next       = total_reg;
        size_code_next   = size_code_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        kind_next        = kind_reg;
        error_next       = error_reg;
        map_we           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        if (take && !error_reg)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (in_byte != dise_pkg::magic_byte(magic_index_reg))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = dise_pkg::RES_ERROR;
                        res.error_code = dise_pkg::ERR_MAGIC;
                    end
                    else
                    begin
                        magic_index_next = 2'(magic_index_reg + 2'd1);
                        if (magic_index_reg == 2'd2)
                            phase_next = PH_COMMENT;
                    end
                end
                PH_COMMENT:
                begin
                    if (in_byte == dise_pkg::COMMENT_END)
                        phase_next = PH_MODE;
                end
                PH_MODE:
                begin
                    if (in_byte > dise_pkg::MAX_MODE)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = dise_pkg::RES_ERROR;
                        res.error_code = dise_pkg::ERR_MODE;
                    end
                    else
                        phase_next = PH_CYL;
                end
                PH_CYL:
                begin
                    if (in_byte > max_cyl_reg)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = dise_pkg::RES_ERROR;
                        res.error_code = dise_pkg::ERR_CYL;
                    end
                    else
                    begin
                        cyl_next   = in_byte;
                        phase_next = PH_HEAD;
                    end
                end
                PH_HEAD:
                begin
                    if (in_byte > dise_pkg::MAX_HEAD)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = dise_pkg::RES_ERROR;
                        res.error_code = dise_pkg::ERR_HEAD;
                    end
                    else
                    begin
                        head_next  = in_byte[0];
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (in_byte > 8'(MAX_SECTORS))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = dise_pkg::RES_ERROR;
                        res.error_code = dise_pkg::ERR_COUNT;
                    end
                    else
                    begin
                        total_next = in_byte;
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    if (in_byte > dise_pkg::MAX_SIZE_CODE
                        || new_size > 14'(MAX_SECTOR_BYTES))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = dise_pkg::RES_ERROR;
                        res.error_code = dise_pkg::ERR_SIZE;
                    end
                    else
                    begin
                        size_code_next = in_byte[2:0];
                        idx_next       = 8'd0;
                        count_next     = 14'd0;
                        phase_next     = (total_reg == 8'd0) ? PH_MODE : PH_MAP;
                    end
                end
                PH_MAP:
                begin
                    map_we = (idx_reg < 8'(MAX_SECTORS));
                    if (idx_inc >= total_reg)
                    begin
                        idx_next   = 8'd0;
                        phase_next = PH_TYPE;
                    end
                    else
                        idx_next = idx_inc;
                end
                PH_TYPE:
                begin
                    count_next = 14'd0;
                    unique case (in_byte) inside
                        dise_pkg::REC_UNAVAIL:
                        begin
                            kind_next         = dise_pkg::KIND_UNAVAIL;
                            res_valid         = 1'b1;
                            res.kind          = dise_pkg::RES_RUN;
                            res.run_value     = fill_reg;
                            res.run_length    = cur_size;
                            res.cylinder      = cyl_reg;
                            res.head          = head_reg;
                            res.sector_number = map_rd_reg;
                            res.record_kind   = dise_pkg::KIND_UNAVAIL;
                            res.sector_end    = 1'b1;
                            idx_next          = idx_inc;
                            phase_next        = (idx_inc >= total_reg) ? PH_MODE : PH_TYPE;
                        end
                        dise_pkg::REC_NORMAL, dise_pkg::REC_NORMAL_ERR:
                        begin
                            kind_next  = dise_pkg::KIND_NORMAL;
                            phase_next = PH_DATA;
                        end
                        dise_pkg::REC_DELETED, dise_pkg::REC_DELETED_ERR:
                        begin
                            kind_next  = dise_pkg::KIND_DELETED;
                            phase_next = PH_DATA;
                        end
                        dise_pkg::REC_COMPRESSED, dise_pkg::REC_DELETED_COMP,
                        dise_pkg::REC_COMPRESSED_ERR, dise_pkg::REC_DELETED_COMP_ERR:
                        begin
                            kind_next  = dise_pkg::KIND_COMPRESSED;
                            phase_next = PH_FILL;
                        end
                        default:
                        begin
                            res_valid      = 1'b1;
                            res.kind       = dise_pkg::RES_ERROR;
                            res.error_code = dise_pkg::ERR_RECTYPE;
                        end
                    endcase
                end
                PH_DATA:
                begin
                    res_valid         = 1'b1;
                    res.kind          = dise_pkg::RES_RUN;
                    res.run_value     = in_byte;
                    res.run_length    = 14'd1;
                    res.cylinder      = cyl_reg;
                    res.head          = head_reg;
                    res.sector_number = map_rd_reg;
                    res.record_kind   = kind_reg;
                    if ({1'b0, count_reg} + 15'd1 >= {1'b0, cur_size})
                    begin
                        res.sector_end = 1'b1;
                        count_next     = 14'd0;
                        idx_next       = idx_inc;
                        phase_next     = (idx_inc >= total_reg) ? PH_MODE : PH_TYPE;
                    end
                    else
                        count_next = 14'(count_reg + 14'd1);
                end
                PH_FILL:
                begin
                    res_valid         = 1'b1;
                    res.kind          = dise_pkg::RES_RUN;
                    res.run_value     = in_byte;
                    res.run_length    = cur_size;
                    res.cylinder      = cyl_reg;
                    res.head          = head_reg;
                    res.sector_number = map_rd_reg;
                    res.record_kind   = kind_reg;
                    res.sector_end    = 1'b1;
                    count_next        = 14'd0;
                    idx_next          = idx_inc;
                    phase_next        = (idx_inc >= total_reg) ? PH_MODE : PH_TYPE;
                end
                PH_HALT:
                begin
                end
                default:
                begin
                end
            endcase

            if (res_valid && res.kind == dise_pkg::RES_ERROR)
            begin
                error_next = 1'b1;
                phase_next = PH_HALT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC;
            magic_index_reg <= 2'd0;
            cyl_reg         <= 8'd0;
            head_reg        <= 1'b0;
            total_reg       <= 8'd0;
            size_code_reg   <= 3'd0;
            idx_reg         <= 8'd0;
            count_reg       <= 14'd0;
            kind_reg        <= 2'd0;
            error_reg       <= 1'b0;
            max_cyl_reg     <= dise_pkg::MAX_CYLINDER_RESET;
            fill_reg        <= dise_pkg::FILL_BYTE_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            magic_index_reg <= magic_index_next;
            cyl_reg         <= cyl_next;
            head_reg        <= head_next;
            total_reg       <= total_next;
            size_code_reg   <= size_code_next;
            idx_reg         <= idx_next;
            count_reg       <= count_next;
            kind_reg        <= kind_next;
            error_reg       <= error_next;
            if (cfg_write && cfg_index == dise_pkg::CFG_MAX_CYLINDER)
                max_cyl_reg <= cfg_data;
            if (cfg_write && cfg_index == dise_pkg::CFG_FILL_BYTE)
                fill_reg <= cfg_data;
        end
    end

    // Numbering map; the read port follows the next sector index so the entry
    // for the current record is always sitting in map_rd_reg.
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[idx_reg[AW-1:0]] <= in_byte;
        if (map_we && idx_reg == idx_next)
            map_rd_reg <= in_byte;
        else if (idx_next < 8'(MAX_SECTORS))
            map_rd_reg <= map_mem[idx_next[AW-1:0]];
        else
            map_rd_reg <= 8'd0;
    end

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |=> error_reg)
        else $error("error latch cleared without reset");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> !res_valid)
        else $error("result produced after error");

    a_error_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == dise_pkg::RES_ERROR) |=> (error_reg && phase_reg == PH_HALT))
        else $error("error report did not halt the parser");

endmodule

`default_nettype wire

[rtl/core/dise_queue.sv]
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module dise_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dise_pkg::result_t push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output dise_pkg::result_t      head_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    dise_pkg::result_t store [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = (PW+1)'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = (PW+1)'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/core/dise_back.sv]
// Output stage: registers one result and hands it to the downstream side.
`timescale 1ns / 1ps
`default_nettype none

module dise_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire dise_pkg::result_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output dise_pkg::result_t      out_data
);

    logic              valid_reg;
    dise_pkg::result_t data_reg;

    // refill whenever the register is empty or its transaction completes
    assign q_pop     = q_not_empty && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_head;
    end

endmodule

`default_nettype wire

[rtl/core/disk_image_sector_expander.sv]
// Top level of the disk image to raw sector run expander.
//
//  channel   dir  handshake            payload
//  input     in   in_valid/in_stall    in_byte
//  output    out  out_valid/out_stall  kind error_code run_value run_length
//                                      cylinder head sector_number record_kind sector_end
//  config    in   cfg_write            cfg_index cfg_data
//
// One input byte per cycle while in_stall is low; each byte yields zero or one result.
// Each result is written into the queue and then into the output register.
// in_stall rises only when the four-entry result queue is full.
// Reset clears parser state and loads register defaults; the map is not cleared.
// After an error report the block keeps taking bytes and discards them.
`timescale 1ns / 1ps
`default_nettype none

module disk_image_sector_expander #(
    parameter int MAX_SECTORS      = 32,
    parameter int MAX_SECTOR_BYTES = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [2:0]       error_code,
    output logic [7:0]       run_value,
    output logic [13:0]      run_length,
    output logic [7:0]       cylinder,
    output logic             head,
    output logic [7:0]       sector_number,
    output logic [1:0]       record_kind,
    output logic             sector_end
);

    logic              take;
    logic              res_valid;
    dise_pkg::result_t res;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    dise_pkg::result_t q_head;
    dise_pkg::result_t out_data;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    dise_front #(
        .MAX_SECTORS      (MAX_SECTORS),
        .MAX_SECTOR_BYTES (MAX_SECTOR_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    dise_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    dise_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    assign kind          = out_data.kind;
    assign error_code    = out_data.error_code;
    assign run_value     = out_data.run_value;
    assign run_length    = out_data.run_length;
    assign cylinder      = out_data.cylinder;
    assign head          = out_data.head;
    assign sector_number = out_data.sector_number;
    assign record_kind   = out_data.record_kind;
    assign sector_end    = out_data.sector_end;

endmodule

`default_nettype wire
